### rtl/tcw_pkg.sv
package tcw_pkg;

	// default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// field widths fixed by the ports
	localparam int OPCODE_W = 2;
	localparam int CHAR_W   = 8;
	localparam int INDEX_W  = 11;
	localparam int COL_W    = 7;
	localparam int LINE_W   = 5;
	localparam int DATA_W   = 16;

	// opcodes of the input item
	localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] NULL_CODE    = 8'd0;

	// No item ever writes an attribute byte; every read returns this
	// constant attribute.
	localparam logic [CHAR_W-1:0] ATTR_BLANK = 8'h00;

	// classified command kinds
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] K_NOP     = 3'd0;
	localparam logic [KIND_W-1:0] K_CHAR    = 3'd1;
	localparam logic [KIND_W-1:0] K_NEWLINE = 3'd2;
	localparam logic [KIND_W-1:0] K_CLEAR   = 3'd3;
	localparam logic [KIND_W-1:0] K_READ    = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CHAR_W-1:0]  ch;
		logic [INDEX_W-1:0] idx;
		logic               idx_ok;
	} cmd_t;

endpackage

### rtl/text_console_writer_core.sv
// channel  | handshake              | fields
// ---------+------------------------+----------------------------------------------
// cmd      | cmd_valid / cmd_stall  | opcode, char_code, cell_index
// res      | res_valid / res_stall  | cursor_column, cursor_line, scrolled, read_data
//
// Put, newline, null and unused items are done in the idle state; a read also
// passes a read state (registered store read). A scroll sweeps COLUMNS cells
// to blank the new bottom row; the screen store is rotated, not moved. A clear
// sweeps ROWS*COLUMNS cells, one cell write per cycle through the single store
// write port. After reset a ROWS*COLUMNS clearing pass runs with cmd_stall high.
// A two-entry queue between front and back lets each side stall on its own.
module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic [INDEX_W-1:0]  cell_index,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [COL_W-1:0]    cursor_column,
	output logic [LINE_W-1:0]   cursor_line,
	output logic                scrolled,
	output logic [DATA_W-1:0]   read_data
);

	logic busy;
	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.opcode    (opcode),
		.char_code (char_code),
		.cell_index(cell_index),
		.busy      (busy),
		.push      (push),
		.push_cmd  (push_cmd),
		.queue_full(queue_full)
	);

	tcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.busy         (busy),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.cursor_column(cursor_column),
		.cursor_line  (cursor_line),
		.scrolled     (scrolled),
		.read_data    (read_data)
	);

endmodule

### rtl/tcw_front.sv
module tcw_front
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic [INDEX_W-1:0]  cell_index,
	input  logic                busy,
	output logic                push,
	output cmd_t                push_cmd,
	input  logic                queue_full
);

	localparam int CELLS = COLUMNS * ROWS;

	logic  front_valid_q;
	cmd_t  front_cmd_q;
	cmd_t  cmd_d;
	logic  accept;

	// classify the incoming item
	always_comb begin
		cmd_d.ch     = char_code;
		cmd_d.idx    = cell_index;
		cmd_d.idx_ok = ({21'b0, cell_index} < 32'(CELLS));
		case (opcode)
			OP_PUT: begin
				if (char_code == NEWLINE_CODE)
					cmd_d.kind = K_NEWLINE;
				else if (char_code == NULL_CODE)
					cmd_d.kind = K_NOP;
				else
					cmd_d.kind = K_CHAR;
			end
			OP_CLEAR: cmd_d.kind = K_CLEAR;
			OP_READ:  cmd_d.kind = K_READ;
			default:  cmd_d.kind = K_NOP;
		endcase
	end

	// hold off during the reset clearing pass, or while the front register holds an item and the queue is full
	assign cmd_stall = busy || (front_valid_q && queue_full);
	assign accept    = cmd_valid && !cmd_stall;
	assign push      = front_valid_q && !queue_full;
	assign push_cmd  = front_cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_valid_q <= 1'b0;
		end else if (accept) begin
			front_valid_q <= 1'b1;
		end else if (push) begin
			front_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_cmd_q <= cmd_d;
		end
	end

endmodule

### rtl/tcw_queue.sv
module tcw_queue
	import tcw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd,
	input  logic pop
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [NW-1:0] count_q;

	assign full       = (count_q == NW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/tcw_back.sv
module tcw_back
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  cmd_t              head_cmd,
	output logic              pop,
	output logic              busy,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [COL_W-1:0]  cursor_column,
	output logic [LINE_W-1:0] cursor_line,
	output logic              scrolled,
	output logic [DATA_W-1:0] read_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	// character store; the attribute byte is constant and not stored
	logic [CHAR_W-1:0] char_mem_q [CELLS];
	logic [CHAR_W-1:0] rdata_q;

	logic [1:0]    state_q, state_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [AW-1:0] base_q, base_d;   // store offset of the cursor row
	logic [AW-1:0] top_q, top_d;     // store offset of the top screen row
	logic [AW-1:0] sweep_addr_q, sweep_addr_d;
	logic [AW-1:0] sweep_last_q, sweep_last_d;
	logic          init_q, init_d;

	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [LINE_W-1:0] out_line_q;
	logic              out_scr_q;
	logic [DATA_W-1:0] out_data_q;

	logic              out_free;
	logic              out_load;
	logic              out_scr;
	logic [DATA_W-1:0] out_data;
	logic              row_adv;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [CHAR_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     cur_addr;
	logic [AW:0]       idx_sum;

	// step a row offset forward by one row, wrapping around the store
	function automatic logic [AW-1:0] next_row(input logic [AW-1:0] a);
		logic [AW:0] s;
		s = {1'b0, a} + (AW+1)'(COLUMNS);
		if (s >= (AW+1)'(CELLS))
			s = s - (AW+1)'(CELLS);
		return AW'(s);
	endfunction

	assign out_free = !out_valid_q || !res_stall;
	assign cur_addr = base_q + AW'(col_q);

	// map a screen index to its place in the rotated store
	always_comb begin
		idx_sum = {1'b0, AW'(head_cmd.idx)} + {1'b0, top_q};
		if (idx_sum >= (AW+1)'(CELLS))
			idx_sum = idx_sum - (AW+1)'(CELLS);
		raddr = AW'(idx_sum);
	end

	// sequence commands, cursor moves and blanking sweeps
	always_comb begin
		pop          = 1'b0;
		we           = 1'b0;
		waddr        = sweep_addr_q;
		wdata        = NULL_CODE;
		re           = 1'b0;
		state_d      = state_q;
		col_d        = col_q;
		row_d        = row_q;
		base_d       = base_q;
		top_d        = top_q;
		sweep_addr_d = sweep_addr_q;
		sweep_last_d = sweep_last_q;
		init_d       = init_q;
		out_load     = 1'b0;
		out_scr      = 1'b0;
		out_data     = '0;
		row_adv      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && out_free) begin
					pop = 1'b1;
					case (head_cmd.kind)
						K_CHAR: begin
							we       = 1'b1;
							waddr    = cur_addr;
							wdata    = head_cmd.ch;
							out_load = 1'b1;
							if (col_q == CW'(COLUMNS - 1))
								row_adv = 1'b1;
							else
								col_d = col_q + 1'b1;
						end
						K_NEWLINE: begin
							out_load = 1'b1;
							row_adv  = 1'b1;
						end
						K_CLEAR: begin
							out_load     = 1'b1;
							col_d        = '0;
							row_d        = '0;
							base_d       = '0;
							top_d        = '0;
							sweep_addr_d = '0;
							sweep_last_d = AW'(CELLS - 1);
							state_d      = ST_SWEEP;
						end
						K_READ: begin
							if (head_cmd.idx_ok) begin
								re      = 1'b1;
								state_d = ST_READ;
							end else begin
								out_load = 1'b1;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
					// next row, scrolling past the bottom
					if (row_adv) begin
						col_d = '0;
						if (row_q == RW'(ROWS - 1)) begin
							top_d        = next_row(top_q);
							base_d       = top_q;
							sweep_addr_d = top_q;
							sweep_last_d = top_q + AW'(COLUMNS - 1);
							state_d      = ST_SWEEP;
							out_scr      = 1'b1;
						end else begin
							row_d  = row_q + 1'b1;
							base_d = next_row(base_q);
						end
					end
				end
			end
			ST_READ: begin
				if (out_free) begin
					out_load = 1'b1;
					out_data = {ATTR_BLANK, rdata_q};
					state_d  = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				we = 1'b1;
				if (sweep_addr_q == sweep_last_q) begin
					state_d = ST_IDLE;
					init_d  = 1'b0;
				end else begin
					sweep_addr_d = sweep_addr_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = init_q;

	// control state; reset starts a sweep over the whole store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			col_q        <= '0;
			row_q        <= '0;
			base_q       <= '0;
			top_q        <= '0;
			sweep_addr_q <= '0;
			sweep_last_q <= AW'(CELLS - 1);
			init_q       <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			col_q        <= col_d;
			row_q        <= row_d;
			base_q       <= base_d;
			top_q        <= top_d;
			sweep_addr_q <= sweep_addr_d;
			sweep_last_q <= sweep_last_d;
			init_q       <= init_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!res_stall)
				out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_col_q  <= COL_W'(col_d);
			out_line_q <= LINE_W'(row_d);
			out_scr_q  <= out_scr;
			out_data_q <= out_data;
		end
	end

	// store write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			char_mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= char_mem_q[raddr];
		end
	end

	assign res_valid     = out_valid_q;
	assign cursor_column = out_col_q;
	assign cursor_line   = out_line_q;
	assign scrolled      = out_scr_q;
	assign read_data     = out_data_q;

endmodule
